### hw/rtl/sptq_pkg.sv
package sptq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int MODE_W = 2;
    localparam int ID_W   = 32;
    localparam int PER_W  = 32;
    localparam int TIME_W = 62;
    localparam int DLY_W  = 32;

    localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIG = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        logic              is_status;
        logic [ID_W-1:0]   fired_id;
        logic [DLY_W-1:0]  next_delay_us;
        logic              queue_empty;
        logic              id_not_found;
        logic              table_full;
        logic              last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_REM_RD,
        S_REM_WR,
        S_INS_PREP,
        S_INS_RD,
        S_INS_CHK,
        S_CNT_RD,
        S_CNT_CHK,
        S_POP,
        S_POP_LD,
        S_FIRE,
        S_STAT_RD,
        S_STAT
    } state_t;

    // Deadline = now + period, saturated at the top of the time range.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
                                                  input logic [PER_W-1:0]  per);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, now} + {{(TIME_W + 1 - PER_W){1'b0}}, per};
            if (sum[TIME_W])
            begin
                sat_add = '1;
            end
            else
            begin
                sat_add = sum[TIME_W-1:0];
            end
        end
    endfunction

endpackage

### hw/rtl/sptq_if.sv
interface sptq_req_if
    import sptq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     timer_id;
    logic [PER_W-1:0]    delay_us;
    logic [TIME_W-1:0]   now_us;

    modport source (output valid, output mode, output timer_id, output delay_us,
                    output now_us, input ready);
    modport sink (input valid, input mode, input timer_id, input delay_us,
                  input now_us, output ready);
endinterface

interface sptq_rsp_if
    import sptq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                is_status;
    logic [ID_W-1:0]     fired_id;
    logic [DLY_W-1:0]    next_delay_us;
    logic                queue_empty;
    logic                id_not_found;
    logic                table_full;
    logic                last;

    modport source (output valid, output is_status, output fired_id,
                    output next_delay_us, output queue_empty, output id_not_found,
                    output table_full, output last, input ready);
    modport sink (input valid, input is_status, input fired_id,
                  input next_delay_us, input queue_empty, input id_not_found,
                  input table_full, input last, output ready);
endinterface

### hw/rtl/sptq_ram.sv
module sptq_ram
    import sptq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sorted_periodic_timer_queue_top.sv
// Channel | Dir | Beat carries
// --------+-----+-----------------------------------------------------------------
// req     | in  | mode, timer_id, delay_us, now_us
// rsp     | out | is_status, fired_id, next_delay_us, queue_empty, id_not_found,
//         |     | table_full, last
//
// One request at a time. The table RAM has a registered read, so each table step is a
// read state then a check or write state. Search scans entries for the ID; remove
// shifts the tail down over the removed slot; insert walks down from the top,
// moving later deadlines up one slot; status reads the head. Trigger counts expired
// head entries, then per fired timer re-arms the head, removes and re-inserts it and
// sends a fire beat; status is last. Reset clears the entry count and the sequencer.
// req is taken only when idle; a held rsp beat stalls the sequencer before the next one.
module sorted_periodic_timer_queue_top
    import sptq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    sptq_req_if.sink   req,
    sptq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     k_reg, k_next;
    logic              out_valid_reg, out_valid_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PER_W-1:0]  delay_reg, delay_next;
    logic [TIME_W-1:0] now_reg, now_next;
    entry_t            new_reg, new_next;
    logic              nf_reg, nf_next;
    logic              full_reg, full_next;
    result_t           out_reg, out_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    entry_t            rdata;

    logic              req_fire;
    logic              out_free;
    logic              id_match;
    logic              expired;
    logic              ins_move;
    logic              rem_done;
    logic              tbl_full;
    logic [PER_W-1:0]  add_b;
    logic [TIME_W-1:0] dl_sum;
    logic [TIME_W-1:0] head_diff;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    state_t            ins_done_state;

    sptq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign id_match = (rdata.id == id_reg);
    assign expired  = (rdata.deadline <= now_reg);
    assign ins_move = (rdata.deadline > new_reg.deadline);
    assign rem_done = (idx_inc >= count_reg);
    assign tbl_full = (count_reg >= CW'(DEPTH));

    // Single deadline adder shared by set and re-arm.
    assign add_b  = (state_reg == S_POP_LD) ? rdata.period : delay_reg;
    assign dl_sum = sat_add(now_reg, add_b);

    assign head_diff = rdata.deadline - now_reg;

    assign ins_done_state = (mode_reg == MODE_TRIG) ? S_FIRE : S_STAT_RD;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.mode)
                        MODE_SET:  state_next = S_FIND_RD;
                        MODE_DEL:  state_next = S_FIND_RD;
                        MODE_TRIG: state_next = S_CNT_RD;
                        default:   state_next = S_STAT_RD;
                    endcase
                end
            end
            S_FIND_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = (mode_reg == MODE_SET) ? S_INS_PREP : S_STAT_RD;
                end
                else
                begin
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                state_next = id_match ? S_REM_RD : S_FIND_RD;
            end
            S_REM_RD:
            begin
                if (rem_done)
                begin
                    state_next = (mode_reg == MODE_DEL) ? S_STAT_RD : S_INS_PREP;
                end
                else
                begin
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                state_next = S_REM_RD;
            end
            S_INS_PREP:
            begin
                if ((mode_reg == MODE_SET) && tbl_full)
                begin
                    state_next = S_STAT_RD;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                state_next = (idx_reg == '0) ? ins_done_state : S_INS_CHK;
            end
            S_INS_CHK:
            begin
                state_next = ins_move ? S_INS_RD : ins_done_state;
            end
            S_CNT_RD:
            begin
                state_next = (k_reg == count_reg) ? S_POP : S_CNT_CHK;
            end
            S_CNT_CHK:
            begin
                state_next = expired ? S_CNT_RD : S_POP;
            end
            S_POP:
            begin
                state_next = (k_reg == '0) ? S_STAT_RD : S_POP_LD;
            end
            S_POP_LD:
            begin
                state_next = S_REM_RD;
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    state_next = S_POP;
                end
            end
            S_STAT_RD:
            begin
                state_next = S_STAT;
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mode_next      = mode_reg;
        id_next        = id_reg;
        delay_next     = delay_reg;
        now_next       = now_reg;
        new_next       = new_reg;
        nf_next        = nf_reg;
        full_next      = full_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = rdata;
        mem_raddr      = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    mode_next  = req.mode;
                    id_next    = req.timer_id;
                    delay_next = req.delay_us;
                    now_next   = req.now_us;
                    nf_next    = 1'b0;
                    full_next  = 1'b0;
                    idx_next   = '0;
                    k_next     = '0;
                end
            end
            S_FIND_RD:
            begin
                if ((idx_reg == count_reg) && (mode_reg == MODE_DEL))
                begin
                    nf_next = 1'b1;
                end
            end
            S_FIND_CHK:
            begin
                if (!id_match)
                begin
                    idx_next = idx_inc;
                end
            end
            S_REM_RD:
            begin
                // shift the tail down over the removed slot
                mem_raddr = idx_inc[AW-1:0];
                if (rem_done)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_REM_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_inc;
            end
            S_INS_PREP:
            begin
                idx_next = count_reg;
                if (mode_reg == MODE_SET)
                begin
                    if (tbl_full)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        new_next.id       = id_reg;
                        new_next.period   = delay_reg;
                        new_next.deadline = dl_sum;
                    end
                end
            end
            S_INS_RD:
            begin
                // walk down from the top, moving later deadlines up one slot
                mem_raddr = idx_dec[AW-1:0];
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = new_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            S_INS_CHK:
            begin
                mem_we = 1'b1;
                if (ins_move)
                begin
                    idx_next = idx_dec;
                end
                else
                begin
                    mem_wdata  = new_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            S_CNT_RD:
            begin
                mem_raddr = k_reg[AW-1:0];
            end
            S_CNT_CHK:
            begin
                if (expired)
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            S_POP:
            begin
                mem_raddr = '0;
            end
            S_POP_LD:
            begin
                // head is always the next expired timer; later re-arms land behind it
                new_next.id       = rdata.id;
                new_next.period   = rdata.period;
                new_next.deadline = dl_sum;
                k_next            = k_reg - CW'(1);
                idx_next          = '0;
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    out_next                = '0;
                    out_next.fired_id       = new_reg.id;
                    out_valid_next          = 1'b1;
                end
            end
            S_STAT_RD:
            begin
                mem_raddr = '0;
            end
            S_STAT:
            begin
                mem_raddr = '0;
                if (out_free)
                begin
                    out_next              = '0;
                    out_next.is_status    = 1'b1;
                    out_next.id_not_found = nf_reg;
                    out_next.table_full   = full_reg;
                    out_next.last         = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_next.queue_empty = 1'b1;
                    end
                    else if (rdata.deadline > now_reg)
                    begin
                        if (|head_diff[TIME_W-1:DLY_W])
                        begin
                            out_next.next_delay_us = '1;
                        end
                        else
                        begin
                            out_next.next_delay_us = head_diff[DLY_W-1:0];
                        end
                    end
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        id_reg    <= id_next;
        delay_reg <= delay_next;
        now_reg   <= now_next;
        new_reg   <= new_next;
        nf_reg    <= nf_next;
        full_reg  <= full_next;
        out_reg   <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.is_status     = out_reg.is_status;
    assign rsp.fired_id      = out_reg.fired_id;
    assign rsp.next_delay_us = out_reg.next_delay_us;
    assign rsp.queue_empty   = out_reg.queue_empty;
    assign rsp.id_not_found  = out_reg.id_not_found;
    assign rsp.table_full    = out_reg.table_full;
    assign rsp.last          = out_reg.last;

endmodule
